/* sv/lvgal_pkg.sv */
// Shared constants for the lead vehicle gap acceleration limit unit.
// Field widths, register reset values and register index codes.
// No dependencies.
package lvgal_pkg;

	localparam int LANE_BITS_DEF = 3;

	localparam int POS_W   = 24;
	localparam int SPEED_W = 16;
	localparam int ACCEL_W = 16;
	localparam int TS_W    = 15;
	localparam int MA_W    = 15;
	localparam int DIST_W  = 16;
	localparam int TRACK_W = 24;
	localparam int NEXT_W  = POS_W + 1;
	localparam int GAP_W   = POS_W + 2;
	localparam int ROOM_W  = POS_W + 3;

	localparam int APB_DW  = 32;
	localparam int APB_AW  = 5;

	localparam logic [TS_W-1:0]    TARGET_SPEED_RST   = 15'd5632;
	localparam logic [MA_W-1:0]    MAX_ACCEL_RST      = 15'd2560;
	localparam logic [DIST_W-1:0]  GAP_BUFFER_RST     = 16'd1536;
	localparam logic [DIST_W-1:0]  VEHICLE_LENGTH_RST = 16'd256;
	localparam logic [TRACK_W-1:0] TRACK_LENGTH_RST   = 24'd1778176;

	localparam logic [2:0] REG_TARGET_SPEED   = 3'd0;
	localparam logic [2:0] REG_MAX_ACCEL      = 3'd1;
	localparam logic [2:0] REG_GAP_BUFFER     = 3'd2;
	localparam logic [2:0] REG_VEHICLE_LENGTH = 3'd3;
	localparam logic [2:0] REG_TRACK_LENGTH   = 3'd4;

endpackage

/* sv/lead_vehicle_gap_accel_limit_unit.sv */
// Lead vehicle gap acceleration limit unit, top level.
// A last_car record passes the input register, s2, s3, output register.
// Throughput: one vehicle record per cycle unless a stalled last_car
// record holds input register s1, where the scan compares and updates.
// Reset: arst_n clears the valid and leader flags and loads reset values
// into the config and best gap registers. Depends on lvgal_pkg.
module lead_vehicle_gap_accel_limit_unit #(
	parameter int LANE_BITS = lvgal_pkg::LANE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lvgal_pkg::APB_AW-1:0]       paddr,
	input  logic [lvgal_pkg::APB_DW-1:0]       pwdata,
	output logic [lvgal_pkg::APB_DW-1:0]       prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [LANE_BITS-1:0]               ego_lane,
	input  logic [lvgal_pkg::POS_W-1:0]        ego_pos,
	input  logic signed [lvgal_pkg::SPEED_W-1:0] ego_speed,
	input  logic signed [lvgal_pkg::ACCEL_W-1:0] ego_accel,
	input  logic                               is_ego_record,
	input  logic [LANE_BITS-1:0]               car_lane,
	input  logic [lvgal_pkg::POS_W-1:0]        car_pos_now,
	input  logic [lvgal_pkg::POS_W-1:0]        car_pos_next,
	input  logic                               last_car,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [15:0]                 accel_limit,
	output logic                               leader_found
);
	import lvgal_pkg::*;

	logic [TS_W-1:0]    target_speed_q;
	logic [MA_W-1:0]    max_accel_q;
	logic [DIST_W-1:0]  gap_buffer_q;
	logic [DIST_W-1:0]  vehicle_length_q;
	logic [TRACK_W-1:0] track_length_q;

	logic               cfg_wr;
	logic [2:0]         cfg_idx;

	logic [POS_W-1:0]   best_gap_q;
	logic [NEXT_W-1:0]  leader_next_pos_q;
	logic               have_leader_q;

	logic                      valid_s1;
	logic [LANE_BITS-1:0]      ego_lane_s1;
	logic [POS_W-1:0]          ego_pos_s1;
	logic signed [SPEED_W-1:0] ego_speed_s1;
	logic signed [ACCEL_W-1:0] ego_accel_s1;
	logic                      is_ego_s1;
	logic [LANE_BITS-1:0]      car_lane_s1;
	logic [POS_W-1:0]          car_pos_now_s1;
	logic [POS_W-1:0]          car_pos_next_s1;
	logic                      last_s1;

	logic                      valid_s2;
	logic [NEXT_W-1:0]         lnp_s2;
	logic                      have_s2;
	logic [POS_W-1:0]          ego_pos_s2;
	logic signed [SPEED_W-1:0] ego_speed_s2;
	logic signed [ACCEL_W-1:0] ego_accel_s2;

	logic                      valid_s3;
	logic signed [ROOM_W-1:0]  base_s3;
	logic signed [17:0]        adv_s3;
	logic signed [17:0]        lim0_s3;
	logic                      have_s3;

	logic                      out_valid_q;
	logic signed [15:0]        accel_limit_q;
	logic                      leader_found_q;

	logic out_en, free_s3, free_s2, free_s1, leave_s1;

	logic                     lane_hit, fwd, bwd, half_ok, ahead, take;
	logic signed [GAP_W-1:0]  fwd_gap, wrap_gap, cand_gap;
	logic [NEXT_W-1:0]        cand_next, lnp_eff;
	logic                     have_eff;

	logic signed [ROOM_W-1:0] base_c;
	logic signed [16:0]       neg_a, half_a;
	logic signed [17:0]       speed_x, adv_c, ts_v, ma_x, lim0_c;

	logic signed [ROOM_W-1:0] room, lim0_w, neg_ma, capped, floored, lim_w;
	logic signed [15:0]       lim_sat;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_speed_q   <= TARGET_SPEED_RST;
			max_accel_q      <= MAX_ACCEL_RST;
			gap_buffer_q     <= GAP_BUFFER_RST;
			vehicle_length_q <= VEHICLE_LENGTH_RST;
			track_length_q   <= TRACK_LENGTH_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TARGET_SPEED:   target_speed_q   <= pwdata[TS_W-1:0];
				REG_MAX_ACCEL:      max_accel_q      <= pwdata[MA_W-1:0];
				REG_GAP_BUFFER:     gap_buffer_q     <= pwdata[DIST_W-1:0];
				REG_VEHICLE_LENGTH: vehicle_length_q <= pwdata[DIST_W-1:0];
				REG_TRACK_LENGTH:   track_length_q   <= pwdata[TRACK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_TARGET_SPEED:   prdata = {{(APB_DW-TS_W){1'b0}}, target_speed_q};
			REG_MAX_ACCEL:      prdata = {{(APB_DW-MA_W){1'b0}}, max_accel_q};
			REG_GAP_BUFFER:     prdata = {{(APB_DW-DIST_W){1'b0}}, gap_buffer_q};
			REG_VEHICLE_LENGTH: prdata = {{(APB_DW-DIST_W){1'b0}}, vehicle_length_q};
			REG_TRACK_LENGTH:   prdata = {{(APB_DW-TRACK_W){1'b0}}, track_length_q};
			default:            prdata = '0;
		endcase
	end

	// pipeline flow control
	assign out_en   = !out_valid_q || out_ready;
	assign free_s3  = !valid_s3 || out_en;
	assign free_s2  = !valid_s2 || free_s3;
	assign free_s1  = !valid_s1 || !last_s1 || free_s2;
	assign in_ready = free_s1;
	assign leave_s1 = valid_s1 && free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= in_valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1 && last_s1;
			end
			if (free_s3) begin
				valid_s3 <= valid_s2;
			end
			if (out_en) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ego_lane_s1     <= ego_lane;
			ego_pos_s1      <= ego_pos;
			ego_speed_s1    <= ego_speed;
			ego_accel_s1    <= ego_accel;
			is_ego_s1       <= is_ego_record;
			car_lane_s1     <= car_lane;
			car_pos_now_s1  <= car_pos_now;
			car_pos_next_s1 <= car_pos_next;
			last_s1         <= last_car;
		end
	end

	// nearest leader scan
	always_comb begin
		lane_hit = !is_ego_s1 && (car_lane_s1 == ego_lane_s1);
		fwd      = car_pos_now_s1 > ego_pos_s1;
		bwd      = car_pos_now_s1 < ego_pos_s1;
		fwd_gap  = $signed({2'b00, car_pos_now_s1}) - $signed({2'b00, ego_pos_s1});
		wrap_gap = $signed({2'b00, car_pos_now_s1}) + $signed({2'b00, track_length_q})
			- $signed({2'b00, ego_pos_s1});
		half_ok  = $signed({wrap_gap[GAP_W-2:0], 1'b0}) < $signed({2'b00, track_length_q});
		ahead    = fwd || (bwd && half_ok);
		cand_gap = fwd ? fwd_gap : wrap_gap;
		take     = lane_hit && ahead && (cand_gap < $signed({2'b00, best_gap_q}));
		cand_next = bwd ? ({1'b0, car_pos_next_s1} + {1'b0, track_length_q})
			: {1'b0, car_pos_next_s1};
		lnp_eff  = take ? cand_next : leader_next_pos_q;
		have_eff = take || have_leader_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_gap_q        <= TRACK_LENGTH_RST;
			leader_next_pos_q <= '0;
			have_leader_q     <= 1'b0;
		end else if (leave_s1) begin
			if (last_s1) begin
				best_gap_q        <= track_length_q;
				leader_next_pos_q <= '0;
				have_leader_q     <= 1'b0;
			end else if (take) begin
				best_gap_q        <= cand_gap[POS_W-1:0];
				leader_next_pos_q <= cand_next;
				have_leader_q     <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s2 && valid_s1 && last_s1) begin
			lnp_s2       <= lnp_eff;
			have_s2      <= have_eff;
			ego_pos_s2   <= ego_pos_s1;
			ego_speed_s2 <= ego_speed_s1;
			ego_accel_s2 <= ego_accel_s1;
		end
	end

	// room terms and speed limit
	always_comb begin
		base_c  = $signed({2'b00, lnp_s2}) - $signed({3'b000, ego_pos_s2})
			- $signed({{(ROOM_W-DIST_W){1'b0}}, gap_buffer_q})
			- $signed({{(ROOM_W-DIST_W){1'b0}}, vehicle_length_q});
		neg_a   = -$signed({ego_accel_s2[ACCEL_W-1], ego_accel_s2});
		half_a  = neg_a >>> 1;
		speed_x = $signed({{2{ego_speed_s2[SPEED_W-1]}}, ego_speed_s2});
		adv_c   = $signed({half_a[16], half_a}) - speed_x;
		ts_v    = $signed({3'b000, target_speed_q}) - speed_x;
		ma_x    = $signed({3'b000, max_accel_q});
		lim0_c  = (ma_x < ts_v) ? ma_x : ts_v;
	end

	always_ff @(posedge clk) begin
		if (free_s3 && valid_s2) begin
			base_s3 <= base_c;
			adv_s3  <= adv_c;
			lim0_s3 <= lim0_c;
			have_s3 <= have_s2;
		end
	end

	// final limit and saturation
	always_comb begin
		room    = base_s3 + $signed({{(ROOM_W-18){adv_s3[17]}}, adv_s3});
		lim0_w  = $signed({{(ROOM_W-18){lim0_s3[17]}}, lim0_s3});
		neg_ma  = -$signed({{(ROOM_W-MA_W){1'b0}}, max_accel_q});
		capped  = (room < lim0_w) ? room : lim0_w;
		floored = (capped < neg_ma) ? neg_ma : capped;
		lim_w   = have_s3 ? floored : lim0_w;
		if (lim_w > $signed(ROOM_W'(32767))) begin
			lim_sat = 16'sd32767;
		end else if (lim_w < -$signed(ROOM_W'(32768))) begin
			lim_sat = -16'sd32768;
		end else begin
			lim_sat = lim_w[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s3) begin
			accel_limit_q  <= lim_sat;
			leader_found_q <= have_s3;
		end
	end

	assign out_valid    = out_valid_q;
	assign accel_limit  = accel_limit_q;
	assign leader_found = leader_found_q;

endmodule
